FILE: hdl/bpa_pkg.sv
package bpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
  localparam int COUNT_W    = 16;
  localparam int STATUS_W   = 2;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h0010_0000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd32768;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_PAGE_COUNT   = 1'b1;

endpackage

FILE: hdl/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bitmap_page_allocator_top.sv
// allocate: bitmap words are read in order up to the first with a free page, which is marked;
//   NO_FREE when no page is free, and no word is read when the limit is zero
// release: word split by reciprocal multiply, bit split and ram read, ram write; none if ignored
// one item in flight; the next transfer is taken once the result is loaded, even while it waits,
//   though loading waits out any output stall; input is held off in the cycle after a register write
// rst is synchronous; a clearing pass then zeroes the MAP_WORDS ram words, one per cycle
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES     = 32768,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bpa_pkg::ADDR_W-1:0]   s_axis_tdata,  // release_address
  input  logic                         s_axis_tuser,  // opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bpa_pkg::ADDR_W-1:0]   m_axis_tdata,  // page_address
  output logic [bpa_pkg::STATUS_W-1:0] m_axis_tuser   // status
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int BIW       = $clog2(MAP_WORD_BITS);
  localparam int LW        = $clog2(MAX_PAGES + 1);
  localparam int PBW       = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
  localparam int PIW       = $clog2(MAX_PAGES);
  localparam int QS        = PIW + BIW;
  localparam int QW        = QS + AW;
  localparam logic [QW-1:0] QM =
    QW'(((64'd1 << QS) + 64'(MAP_WORD_BITS - 1)) / 64'(MAP_WORD_BITS));

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_RREAD  = 7'b0010000,
    ST_RWRITE = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [bpa_pkg::ADDR_W-1:0]   base_address;
  logic [bpa_pkg::COUNT_W-1:0]  page_count;
  logic [LW-1:0]                lim;
  logic [LW-1:0]                lim_next;
  logic                         cfg_hold;

  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                scan_word;
  logic [PBW-1:0]               issue_pb;
  logic                         ev_valid;
  logic [PBW-1:0]               ev_pb;
  logic [AW-1:0]                ev_word;

  logic [PIW-1:0]               pidx;
  logic [AW-1:0]                rel_word;
  logic [BIW-1:0]               rem;
  logic [QW-1:0]                q_prod;

  logic [bpa_pkg::ADDR_W-1:0]   res_addr;
  logic [bpa_pkg::STATUS_W-1:0] res_status;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [MAP_WORD_BITS-1:0]     ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [MAP_WORD_BITS-1:0]     ram_rdata;

  logic [bpa_pkg::ADDR_W-1:0]   base_m;
  logic [bpa_pkg::ADDR_W-1:0]   room;
  logic [bpa_pkg::ADDR_W-1:0]   lim_w;
  logic [bpa_pkg::ADDR_W-1:0]   rel_diff;
  logic [bpa_pkg::PNUM_W-1:0]   rel_idx;
  logic                         rel_ign;
  logic                         in_xfer;

  logic [bpa_pkg::ADDR_W-1:0]   pages_left;
  logic [MAP_WORD_BITS-1:0]     free_mask;
  logic                         hit;
  logic [BIW-1:0]               hit_j;
  logic [PBW-1:0]               alloc_idx;
  logic [bpa_pkg::ADDR_W-1:0]   alloc_addr;
  logic                         issue_more;

  // effective page limit
  always_comb begin
    base_m = {base_address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT],
              {bpa_pkg::PAGE_SHIFT{1'b0}}};
    room   = (bpa_pkg::ADDR_W'(1) << bpa_pkg::PNUM_W)
           - bpa_pkg::ADDR_W'(base_address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT]);
    lim_w  = room;
    if (bpa_pkg::ADDR_W'(page_count) < lim_w) begin
      lim_w = bpa_pkg::ADDR_W'(page_count);
    end
    if (bpa_pkg::ADDR_W'(MAX_PAGES) < lim_w) begin
      lim_w = bpa_pkg::ADDR_W'(MAX_PAGES);
    end
    lim_next = lim_w[LW-1:0];
  end

  // release address check
  always_comb begin
    in_xfer  = s_axis_tvalid && s_axis_tready;
    rel_diff = s_axis_tdata - base_m;
    rel_idx  = rel_diff[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    rel_ign  = (s_axis_tdata == '0) || (s_axis_tdata < base_m)
            || (bpa_pkg::ADDR_W'(rel_idx) >= bpa_pkg::ADDR_W'(lim));
  end

  // lowest free page within the word under evaluation
  always_comb begin
    pages_left = bpa_pkg::ADDR_W'(lim) - bpa_pkg::ADDR_W'(ev_pb);
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      free_mask[j] = !ram_rdata[j] && (bpa_pkg::ADDR_W'(j) < pages_left);
    end
    hit_j = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (free_mask[j]) begin
        hit_j = BIW'(j);
      end
    end
    hit        = ev_valid && (|free_mask);
    alloc_idx  = ev_pb + PBW'(hit_j);
    alloc_addr = base_m + (bpa_pkg::ADDR_W'(alloc_idx) << bpa_pkg::PAGE_SHIFT);
    issue_more = bpa_pkg::ADDR_W'(issue_pb) < bpa_pkg::ADDR_W'(lim);
  end

  // word index of the released page by reciprocal multiply
  always_comb begin
    q_prod = QW'(pidx) * QM;
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rel_word;
    ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << rem);
    ram_raddr = rel_word;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        ram_we    = hit;
        ram_waddr = ev_word;
        ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << hit_j);
        ram_raddr = scan_word;
      end
      ST_RWRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE) && !cfg_hold;

  always_ff @(posedge clk) begin
    lim <= lim_next;
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      ev_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      cfg_hold      <= 1'b0;
      base_address  <= bpa_pkg::BASE_RESET;
      page_count    <= bpa_pkg::COUNT_RESET;
    end else begin
      cfg_hold <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          bpa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
          bpa_pkg::REG_PAGE_COUNT:   page_count   <= cfg_data[bpa_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == bpa_pkg::OP_ALLOC) begin
              scan_word <= '0;
              issue_pb  <= '0;
              ev_valid  <= 1'b0;
              state     <= ST_SCAN;
            end else if (rel_ign) begin
              res_addr   <= '0;
              res_status <= bpa_pkg::STATUS_IGNORED;
              state      <= ST_OUT;
            end else begin
              pidx  <= rel_idx[PIW-1:0];
              state <= ST_DIV;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_addr   <= alloc_addr;
            res_status <= bpa_pkg::STATUS_DONE;
            ev_valid   <= 1'b0;
            state      <= ST_OUT;
          end else if (issue_more) begin
            ev_valid  <= 1'b1;
            ev_pb     <= issue_pb;
            ev_word   <= scan_word;
            scan_word <= scan_word + 1'b1;
            issue_pb  <= issue_pb + PBW'(MAP_WORD_BITS);
          end else begin
            ev_valid <= 1'b0;
            if (!ev_valid) begin
              res_addr   <= '0;
              res_status <= bpa_pkg::STATUS_NO_FREE;
              state      <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          rel_word <= q_prod[QS +: AW];
          state    <= ST_RREAD;
        end
        ST_RREAD: begin
          rem   <= BIW'(pidx - PIW'(rel_word) * PIW'(MAP_WORD_BITS));
          state <= ST_RWRITE;
        end
        ST_RWRITE: begin
          res_addr   <= '0;
          res_status <= bpa_pkg::STATUS_DONE;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= res_addr;
            m_axis_tuser  <= res_status;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bpa_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != ST_IDLE)
    else $error("input transfer did not start work");

  a_scan_write_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ram_we) |=> state == ST_OUT)
    else $error("scan kept running after marking a page");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_RWRITE |-> $past(state == ST_RREAD))
    else $error("release write without preceding read");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("result shown outside output state");
`endif

endmodule

FILE: tb/bpa_checker.sv
module bpa_checker
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = 32768
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [ADDR_W-1:0]   s_axis_tdata,  // release_address
  input  logic                s_axis_tuser,  // opcode
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [ADDR_W-1:0]   m_axis_tdata,  // page_address
  input  logic [STATUS_W-1:0] m_axis_tuser,  // status
  output int                  pending,
  output int                  errors,
  output int                  checked,
  output int                  exhausted,
  output int                  ignored
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_WORDS = MAX_PAGES / 32;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
  } page_result_t;

  logic [31:0]        used_words [MAP_WORDS];
  logic [ADDR_W-1:0]  base_reg;
  logic [COUNT_W-1:0] count_reg;
  page_result_t       expected_pages [$];

  // pages usable under the current setting, never past the top of the address space
  function automatic int unsigned page_limit();
    logic [ADDR_W:0] room;
    int unsigned     lim;
    room = {1'b1, {ADDR_W{1'b0}}} - {1'b0, base_reg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    lim = int'(room >> PAGE_SHIFT);
    if (count_reg < lim) lim = count_reg;
    if (MAX_PAGES < lim) lim = MAX_PAGES;
    return lim;
  endfunction

  function automatic page_result_t allocate_or_release(logic op, logic [ADDR_W-1:0] addr);
    page_result_t      r;
    logic [ADDR_W-1:0] base;
    int unsigned       lim;
    int unsigned       idx;
    int unsigned       w;
    int                b;
    base = {base_reg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    lim = page_limit();
    r.page_address = '0;
    r.status = STATUS_DONE;
    if (op == OP_ALLOC) begin
      r.status = STATUS_NO_FREE;
      for (w = 0; w * 32 < lim; w++) begin
        if (used_words[w] != '1) begin
          for (b = 0; b < 32; b++) begin
            idx = w * 32 + b;
            if (idx < lim && !used_words[w][b]) begin
              used_words[w][b] = 1'b1;
              r.page_address = base + (idx << PAGE_SHIFT);
              r.status = STATUS_DONE;
              return r;
            end
          end
        end
      end
    end else if (addr == '0 || addr < base) begin
      r.status = STATUS_IGNORED;
    end else begin
      idx = (addr - base) >> PAGE_SHIFT;
      if (idx >= lim) r.status = STATUS_IGNORED;
      else used_words[idx / 32][idx % 32] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    int           w;
    if (rst) begin
      for (w = 0; w < MAP_WORDS; w++) used_words[w] = '0;
      base_reg = BASE_RESET;
      count_reg = COUNT_RESET;
      expected_pages.delete();
      errors = 0;
      checked = 0;
      exhausted = 0;
      ignored = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BASE_ADDRESS) base_reg = cfg_data;
        else count_reg = cfg_data[COUNT_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (expected_pages.size() == 0) begin
          $error("result transfer with nothing expected: page_address %h status %0d",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = expected_pages.pop_front();
          if (want.status == STATUS_NO_FREE) exhausted++;
          if (want.status == STATUS_IGNORED) ignored++;
          if (m_axis_tdata !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pages.push_back(allocate_or_release(s_axis_tuser, s_axis_tdata));
    end
    pending = expected_pages.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int MAX_PAGES   = 32768;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 143;
  localparam int HOLD_CYCLES = 300;
  localparam int END_DRAIN   = 1100;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [ADDR_W-1:0]   cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ADDR_W-1:0]   s_axis_tdata;  // release_address
  logic                s_axis_tuser;  // opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ADDR_W-1:0]   m_axis_tdata;  // page_address
  logic [STATUS_W-1:0] m_axis_tuser;  // status

  int pending;
  int errors;
  int checked;
  int exhausted;
  int ignored;

  logic [ADDR_W-1:0]  cur_base;
  logic [COUNT_W-1:0] cur_count;
  int                 settings;
  logic               calm;
  logic               hold_request;
  int unsigned        idle_pct;

  always #2 clk = ~clk;

  bitmap_page_allocator_top #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (32)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bpa_checker #(
    .MAX_PAGES (MAX_PAGES)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending       (pending),
    .errors        (errors),
    .checked       (checked),
    .exhausted     (exhausted),
    .ignored       (ignored)
  );

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= addr;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic settle(input int unsigned tail);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_BASE_ADDRESS) cur_base = data;
    else cur_count = data[COUNT_W-1:0];
    settings++;
  endtask

  task automatic random_setting(input int phase);
    logic [ADDR_W-1:0] b;
    int unsigned       c;
    case (phase % 5)
      0: b = $urandom_range(0, 16'hFFFF) << PAGE_SHIFT;
      1: b = $urandom;
      2: b = (32'hFFFF_F000 - ($urandom_range(0, 64) << PAGE_SHIFT)) | $urandom_range(0, 4095);
      3: b = '0;
      default: b = BASE_RESET;
    endcase
    case ($urandom_range(0, 7))
      0: c = 0;
      1: c = MAX_PAGES;
      2: c = $urandom_range(1, MAX_PAGES);
      default: c = $urandom_range(1, 96);
    endcase
    write_reg(REG_BASE_ADDRESS, b);
    write_reg(REG_PAGE_COUNT, c);
  endtask

  task automatic random_item();
    int unsigned       pick;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;
    pick = $urandom_range(0, 99);
    addr = $urandom;
    base = {cur_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    if (pick < 50) begin
      send_item(OP_ALLOC, addr);
    end else begin
      if (pick < 85)
        addr = base + ($urandom_range(0, cur_count + 1) << PAGE_SHIFT)
               + ($urandom_range(0, 1) ? addr[PAGE_SHIFT-1:0] : '0);
      else if (pick < 97 && pick >= 95)
        addr = '0;
      else if (pick >= 97)
        addr = base - $urandom_range(1, 4096);
      send_item(OP_RELEASE, addr);
    end
  endtask

  initial begin
    cfg_we        <= 1'b0;
    cfg_index     <= REG_BASE_ADDRESS;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ALLOC;
    m_axis_tready <= 1'b0;
  end

  // receiver: random stalls, one long hold on request, none in the last phase
  initial begin
    @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  initial begin
    #35ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    calm = 1'b0;
    hold_request = 1'b0;
    settings = 0;
    cur_base = BASE_RESET;
    cur_count = COUNT_RESET;
    rst <= 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default setting: first fit, zero and out of range releases, unaligned release
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h1234_5678);
    send_item(OP_RELEASE, '0);
    send_item(OP_RELEASE, 32'h000F_FFFF);
    send_item(OP_RELEASE, 32'h0010_1234);
    send_item(OP_RELEASE, 32'h0010_1000);
    send_item(OP_RELEASE, 32'h0810_0000);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, '0);
    settle(4);
    // no pages at all
    write_reg(REG_PAGE_COUNT, 0);
    send_item(OP_ALLOC, '0);
    send_item(OP_RELEASE, 32'h0010_0000);
    settle(4);
    // fill a tiny pool until exhausted
    write_reg(REG_PAGE_COUNT, 4);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    settle(4);
    // pool shrunk below pages in use
    write_reg(REG_PAGE_COUNT, 2);
    send_item(OP_RELEASE, 32'h0010_3000);
    send_item(OP_RELEASE, 32'h0010_0000);
    send_item(OP_ALLOC, '0);
    settle(4);
    // base near the top with its low bits set, pool capped by the address space
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_EFFF);
    write_reg(REG_PAGE_COUNT, MAX_PAGES);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    settle(4);
    write_reg(REG_BASE_ADDRESS, '0);
    send_item(OP_RELEASE, '0);
    send_item(OP_ALLOC, '0);
    settle(4);
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_F000);
    send_item(OP_ALLOC, '0);

    for (int p = 0; p < N_PHASES; p++) begin
      settle(4);
      random_setting(p);
      calm = (p == N_PHASES - 1);
      idle_pct = calm ? 0 : $urandom_range(0, 40);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 20) hold_request = 1'b1;
        if (p == 4 && k == PHASE_ITEMS / 2) settle(4);
        if ($urandom_range(0, 99) < idle_pct) pause_input($urandom_range(1, 18));
        random_item();
      end
    end

    settle(END_DRAIN);
    $display("summary: %0d transfers checked across %0d register writes", checked, settings);
    $display("summary: %0d refused for lack of a free page, %0d releases ignored",
             exhausted, ignored);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
